### rtl/text_line_number_squeeze_filter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line number and squeeze filter
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_LINE_NUMBER_SQUEEZE_FILTER_DEFINES_SVH
`define TEXT_LINE_NUMBER_SQUEEZE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define TLNSF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define TLNSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define TLNSF_ASSERT_IMPL(lbl, ante, cons, msg)
`define TLNSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/tlnsf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlnsf_pkg
// Shared constants, register codes and queue entry type.
// ---------------------------------------------------------------------------
package tlnsf_pkg;

	localparam int NUMBER_DIGITS_DEF = 6;
	localparam int QUEUE_DEPTH_DEF   = 4;
	localparam int CFG_INDEX_W       = 2;
	localparam int CFG_DATA_W        = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NUMBER_LINES = 2'd0,
		REG_SKIP_EMPTY   = 2'd1,
		REG_SQUEEZE      = 2'd2,
		REG_RESTART      = 2'd3
	} cfg_reg_t;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_TAB     = 8'd9;
	localparam logic [7:0] CHAR_SPACE   = 8'd32;
	localparam logic [7:0] CHAR_ZERO    = 8'd48;

	// control part of one queued command; the BCD digits travel beside it
	typedef struct packed {
		logic       number;
		logic [7:0] text_byte;
	} cmd_ctl_t;

endpackage

### rtl/tlnsf_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlnsf_if
// Valid/ready channels for text input and filtered output.
// ---------------------------------------------------------------------------
interface tlnsf_in_if ();
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       file_start;

	modport source (output valid, output text_byte, output file_start, input ready);
	modport sink (input valid, input text_byte, input file_start, output ready);
endinterface

interface tlnsf_out_if ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;

	modport source (output valid, output out_byte, output run_end, input ready);
	modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

### rtl/tlnsf_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlnsf_queue
// Small register FIFO between front and back end.
// ---------------------------------------------------------------------------
module tlnsf_queue #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

### rtl/tlnsf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlnsf_front
// Classifies each byte: line start, blank run, drop; keeps the BCD counter.
// ---------------------------------------------------------------------------
module tlnsf_front
	import tlnsf_pkg::*;
#(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tlnsf_in_if.sink                   text,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output logic                       cmd_push,
	output cmd_ctl_t                   cmd_ctl,
	output logic [4*NUMBER_DIGITS-1:0] cmd_digits,
	input  logic                       cmd_full
);
	localparam int BW = 4 * NUMBER_DIGITS;
	localparam logic [BW-1:0] BCD_ONE = BW'(1);

	logic          number_lines_q;
	logic          skip_empty_q;
	logic          squeeze_q;
	logic          restart_q;
	logic          prev_newline_q;
	logic [1:0]    blank_run_q;
	logic [BW-1:0] count_q;

	logic          accept;
	logic          is_nl;
	logic          line_prev;
	logic [BW-1:0] count_base;
	logic [1:0]    blank_next;
	logic          keep;
	logic          line_start;

	// saturating BCD increment, ripple over the digits
	function automatic logic [BW-1:0] bcd_inc(input logic [BW-1:0] v);
		logic [BW-1:0] r;
		logic          carry;
		logic          sat;
		r     = v;
		carry = 1'b1;
		sat   = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (v[4*i +: 4] != 4'd9) sat = 1'b0;
			if (carry) begin
				if (v[4*i +: 4] >= 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = v[4*i +: 4] + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		return sat ? v : r;
	endfunction

	assign text.ready = !cmd_full;
	assign accept     = text.valid && !cmd_full;
	assign is_nl      = (text.text_byte == CHAR_NEWLINE);
	assign line_prev  = text.file_start || prev_newline_q;
	assign count_base = (text.file_start && restart_q) ? BCD_ONE : count_q;

	always_comb begin
		if (line_prev && is_nl) begin
			blank_next = (blank_run_q == 2'd2) ? 2'd2 : blank_run_q + 2'd1;
		end else begin
			blank_next = 2'd0;
		end
	end

	assign keep       = !squeeze_q || (blank_next != 2'd2);
	assign line_start = keep && line_prev && !(is_nl && skip_empty_q);

	assign cmd_push            = accept && keep;
	assign cmd_ctl.number      = line_start && number_lines_q;
	assign cmd_ctl.text_byte   = text.text_byte;
	assign cmd_digits          = count_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_lines_q <= 1'b0;
			skip_empty_q   <= 1'b0;
			squeeze_q      <= 1'b0;
			restart_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NUMBER_LINES: number_lines_q <= cfg_data[0];
				REG_SKIP_EMPTY:   skip_empty_q   <= cfg_data[0];
				REG_SQUEEZE:      squeeze_q      <= cfg_data[0];
				REG_RESTART:      restart_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_newline_q <= 1'b0;
			blank_run_q    <= 2'd0;
			count_q        <= BCD_ONE;
		end else if (accept) begin
			prev_newline_q <= is_nl;
			blank_run_q    <= blank_next;
			count_q        <= line_start ? bcd_inc(count_base) : count_base;
		end
	end
endmodule

### rtl/tlnsf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlnsf_back
// Expands one command into its text byte, after number digits and a tab if numbered.
// ---------------------------------------------------------------------------
module tlnsf_back
	import tlnsf_pkg::*;
#(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  cmd_ctl_t                   cmd_ctl,
	input  logic [4*NUMBER_DIGITS-1:0] cmd_digits,
	output logic                       cmd_pop,
	tlnsf_out_if.source                listing
);
	localparam int BW = 4 * NUMBER_DIGITS;
	localparam int PW = $clog2(NUMBER_DIGITS + 2);
	localparam logic [PW-1:0] TAB_POS  = PW'(NUMBER_DIGITS);
	localparam logic [PW-1:0] LAST_POS = PW'(NUMBER_DIGITS + 1);

	logic                     busy_q;
	logic [PW-1:0]            pos_q;
	cmd_ctl_t                 ctl_q;
	logic [BW-1:0]            digits_q;

	logic                     xfer;
	logic                     last;
	logic [NUMBER_DIGITS-1:0] blank;
	logic                     lead;
	logic [3:0]               d;
	logic [7:0]               char_sel;

	assign xfer    = busy_q && listing.ready;
	assign last    = (pos_q == LAST_POS);
	assign cmd_pop = cmd_valid && (!busy_q || (xfer && last));

	// leading zeros print as spaces, the units digit always prints
	always_comb begin
		lead  = 1'b1;
		blank = '0;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			if (digits_q[4*i +: 4] != 4'd0) lead = 1'b0;
			blank[i] = lead && (i != 0);
		end
	end

	always_comb begin
		char_sel = ctl_q.text_byte;
		d        = 4'd0;
		if (pos_q == TAB_POS) char_sel = CHAR_TAB;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (pos_q == PW'(i)) begin
				d = digits_q[4*(NUMBER_DIGITS-1-i) +: 4];
				if (d > 4'd9) d = 4'd9;
				char_sel = blank[NUMBER_DIGITS-1-i] ? CHAR_SPACE : (CHAR_ZERO | {4'd0, d});
			end
		end
	end

	assign listing.valid    = busy_q;
	assign listing.run_end  = last;
	assign listing.out_byte = char_sel;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ctl_q    <= cmd_ctl;
			digits_q <= cmd_digits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (cmd_pop) begin
			busy_q <= 1'b1;
			pos_q  <= cmd_ctl.number ? '0 : LAST_POS;
		end else if (xfer) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end
endmodule

### rtl/text_line_number_squeeze_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_line_number_squeeze_filter
// Line numbering and blank squeezing filter for a text byte stream.
// ---------------------------------------------------------------------------
// Usage:
//  - text: one transfer per text byte, file_start marks a file's first byte.
//  - listing: the filtered bytes; run_end flags the last byte caused by one
//    input byte. A squeezed newline causes no output transfer at all.
//  - cfg_we/cfg_index/cfg_data: register writes, only while the block idles.
// Timing:
//  - The front end classifies a byte and updates the line counter in the
//    cycle it is taken, so text accepts one byte per cycle while the queue
//    has room.
//  - An input byte's command passes through a queue entry and then the
//    back end's command registers before its first output transfer.
//  - The back end sends one byte per cycle while listing is ready: one byte
//    for a plain byte, and NUMBER_DIGITS+2 bytes for a numbered line start;
//    that output port sets the sustained rate.
//  - QUEUE_DEPTH commands absorb line-start bursts; a stalled listing fills
//    the queue and then drops text.ready.
// Reset: counter back to one, all options off, queue emptied; no sweep.
// ---------------------------------------------------------------------------
`include "text_line_number_squeeze_filter_defines.svh"

module text_line_number_squeeze_filter
	import tlnsf_pkg::*;
#(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tlnsf_in_if.sink               text,
	tlnsf_out_if.source            listing,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);
	localparam int BW = 4 * NUMBER_DIGITS;
	localparam int CTL_W = $bits(cmd_ctl_t);
	localparam int QW = BW + CTL_W;

	// front end -> queue
	logic           q_push;
	logic           q_full;
	cmd_ctl_t       f_ctl;
	logic [BW-1:0]  f_digits;

	// queue -> back end
	logic           q_pop;
	logic           q_valid;
	logic [QW-1:0]  q_out;
	cmd_ctl_t       b_ctl;
	logic [BW-1:0]  b_digits;

	tlnsf_front #(
		.NUMBER_DIGITS (NUMBER_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_push   (q_push),
		.cmd_ctl    (f_ctl),
		.cmd_digits (f_digits),
		.cmd_full   (q_full)
	);

	// one entry = counter snapshot + control
	tlnsf_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_digits, f_ctl}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.valid     (q_valid)
	);

	assign b_ctl    = cmd_ctl_t'(q_out[CTL_W-1:0]);
	assign b_digits = q_out[QW-1 -: BW];

	tlnsf_back #(
		.NUMBER_DIGITS (NUMBER_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_ctl    (b_ctl),
		.cmd_digits (b_digits),
		.cmd_pop    (q_pop),
		.listing    (listing)
	);

	// checks
	`TLNSF_ASSERT_IMPL(a_push_has_room, q_push, !q_full, "command pushed into full queue")
	`TLNSF_ASSERT_IMPL(a_pop_has_data, q_pop, q_valid, "command popped from empty queue")
	`TLNSF_ASSERT_IMPL(a_text_queued, text.valid && text.ready && (text.text_byte != CHAR_NEWLINE), q_push, "non-newline byte was dropped")
	`TLNSF_ASSERT_NEXT(a_run_continues, listing.valid && listing.ready && !listing.run_end, listing.valid, "output run broken before run_end")
endmodule

### tb/tb_text_line_number_squeeze_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_line_number_squeeze_filter
// Self-checking bench for the line numbering and blank squeezing filter.
// A scoreboard class tracks the line counter, blank run and options, and
// predicts the listing bytes for every accepted text byte. Directed cases
// and a counting run with numbering off run without idling; randomized
// phases over all option settings mostly add random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module tb_text_line_number_squeeze_filter;
	import tlnsf_pkg::*;

	localparam int DIGITS      = NUMBER_DIGITS_DEF;
	localparam int BCD_W       = 4 * DIGITS;
	// newlines counted with numbering off, enough for a two-digit number
	localparam int COUNT_LINES = 12;

	// one expected listing transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
	} listing_byte_t;

	// -----------------------------------------------------------------------
	// Scoreboard: own copy of options and filter state, plus the queue of
	// listing bytes still owed by the block.
	// -----------------------------------------------------------------------
	class listing_scoreboard;
		bit              number_lines;
		bit              skip_empty;
		bit              squeeze;
		bit              restart;
		bit              prev_newline;
		bit [1:0]        blank_run;
		logic [BCD_W-1:0] line_bcd;
		listing_byte_t   owed_bytes[$];
		int              errors;

		function new();
			number_lines = 1'b0;
			skip_empty   = 1'b0;
			squeeze      = 1'b0;
			restart      = 1'b0;
			prev_newline = 1'b0;
			blank_run    = 2'd0;
			line_bcd     = BCD_W'(1);
			errors       = 0;
		endfunction

		function void set_reg(cfg_reg_t r, bit v);
			case (r)
				REG_NUMBER_LINES: number_lines = v;
				REG_SKIP_EMPTY:   skip_empty   = v;
				REG_SQUEEZE:      squeeze      = v;
				REG_RESTART:      restart      = v;
				default: ;
			endcase
		endfunction

		// BCD increment, holding at all nines
		function logic [BCD_W-1:0] bcd_next(logic [BCD_W-1:0] v);
			logic [BCD_W-1:0] r;
			logic [3:0]       d;
			bit               done;
			r    = v;
			done = 1'b0;
			if (v == {DIGITS{4'h9}})
				return v;
			for (int k = 0; k < DIGITS; k++) begin
				d = r[4*k +: 4];
				if (!done) begin
					if (d >= 4'd9) begin
						r[4*k +: 4] = 4'd0;
					end else begin
						r[4*k +: 4] = d + 4'd1;
						done        = 1'b1;
					end
				end
			end
			return r;
		endfunction

		function void owe(logic [7:0] b);
			listing_byte_t e;
			e.out_byte = b;
			e.run_end  = 1'b0;
			owed_bytes.push_back(e);
		endfunction

		// accepted text transfer: advance state, queue the listing bytes
		function void note_text(logic [7:0] b, logic fs);
			bit            is_nl;
			bit            leading;
			int            first;
			logic [3:0]    d;
			listing_byte_t last;
			is_nl = (b == CHAR_NEWLINE);
			first = owed_bytes.size();
			if (fs) begin
				if (restart)
					line_bcd = BCD_W'(1);
				prev_newline = 1'b1;
			end
			if (prev_newline && is_nl) begin
				if (blank_run < 2'd2)
					blank_run = blank_run + 2'd1;
			end else begin
				blank_run = 2'd0;
			end
			if (!squeeze || blank_run < 2'd2) begin
				if (prev_newline && !(is_nl && skip_empty)) begin
					if (number_lines) begin
						leading = 1'b1;
						for (int k = DIGITS - 1; k >= 0; k--) begin
							d = line_bcd[4*k +: 4];
							if (leading && d == 4'd0 && k != 0) begin
								owe(CHAR_SPACE);
							end else begin
								leading = 1'b0;
								owe(CHAR_ZERO + {4'd0, d});
							end
						end
						owe(CHAR_TAB);
					end
					line_bcd = bcd_next(line_bcd);
				end
				owe(b);
			end
			prev_newline = is_nl;
			if (owed_bytes.size() > first) begin
				last         = owed_bytes.pop_back();
				last.run_end = 1'b1;
				owed_bytes.push_back(last);
			end
		endfunction

		// accepted listing transfer: compare with the oldest owed byte
		function void check_listing(logic [7:0] b, logic re);
			listing_byte_t e;
			if (owed_bytes.size() == 0) begin
				errors++;
				$display("%0t listing: unexpected transfer, expected none, actual byte %h run_end %b",
					$time, b, re);
				return;
			end
			e = owed_bytes.pop_front();
			if (b !== e.out_byte) begin
				errors++;
				$display("%0t listing out_byte: expected %h actual %h", $time, e.out_byte, b);
			end
			if (re !== e.run_end) begin
				errors++;
				$display("%0t listing run_end: expected %b actual %b", $time, e.run_end, re);
			end
		endfunction

		function int pending();
			return owed_bytes.size();
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// Clock, reset, channels and the block
	// -----------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tlnsf_in_if  text_ch ();
	tlnsf_out_if listing_ch ();

	text_line_number_squeeze_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text_ch.sink),
		.listing   (listing_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	listing_scoreboard board = new();

	// idling knobs, changed per phase by the stimulus process
	int gap_max      = 0;  // sender: idle cycles before an item, 0..gap_max
	int stall_max    = 0;  // receiver: stall cycles before a transfer
	int listing_hold = 0;  // one-shot long receiver hold-off, in cycles

	// -----------------------------------------------------------------------
	// Text side helpers. All drive at the falling edge; acceptance is seen
	// at the rising edge with the pre-edge values of valid and ready.
	// -----------------------------------------------------------------------

	// Offer one byte. Entered and left at a falling edge; valid stays high
	// on exit so that a back-to-back item needs no lower/raise.
	task automatic send_text(input logic [7:0] b, input logic fs);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid      <= 1'b1;
		text_ch.text_byte  <= b;
		text_ch.file_start <= fs;
		do @(posedge clk); while (!text_ch.ready);
		board.note_text(b, fs);
		@(negedge clk);
	endtask

	// Drop valid and wait until the block owes nothing more.
	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
	endtask

	// Idle point for register writes: drained, plus a few cycles in case the
	// last byte was a squeezed newline still inside the front end.
	task automatic settle();
		wait_drained();
		repeat (4) @(negedge clk);
	endtask

	// One register write; cfg_we is left high for a following write.
	task automatic write_reg(input cfg_reg_t r, input bit v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		board.set_reg(r, v);
		@(negedge clk);
	endtask

	task automatic configure(input bit nl, input bit se, input bit sq, input bit rs);
		write_reg(REG_NUMBER_LINES, nl);
		write_reg(REG_SKIP_EMPTY, se);
		write_reg(REG_SQUEEZE, sq);
		write_reg(REG_RESTART, rs);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Listing receiver: draws a stall per transfer, honors a one-shot long
	// hold-off, and checks every accepted byte.
	// -----------------------------------------------------------------------
	initial begin
		int stall;
		listing_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (listing_hold > 0) begin
				stall        = listing_hold;
				listing_hold = 0;
			end else begin
				stall = $urandom_range(0, stall_max);
			end
			if (stall > 0) begin
				listing_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			listing_ch.ready <= 1'b1;
			do @(posedge clk); while (!listing_ch.valid);
			board.check_listing(listing_ch.out_byte, listing_ch.run_end);
			@(negedge clk);
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------
	initial begin
		logic [7:0] b;
		logic       fs;
		bit [3:0]   opts;
		text_ch.valid      = 1'b0;
		text_ch.text_byte  = 8'd0;
		text_ch.file_start = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_NUMBER_LINES;
		cfg_data           = 1'b0;
		arst_n             = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// -- directed --------------------------------------------------------
		// Reset options: no line start before a newline or file start; the
		// line after the newline is counted even though numbering is off.
		send_text("A", 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text("B", 1'b0);
		settle();

		// Numbering on: file start opens a line, then blank lines numbered.
		configure(1'b1, 1'b0, 1'b0, 1'b0);
		send_text("x", 1'b1);
		send_text("y", 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text("z", 1'b0);
		settle();

		// Every option on: restart, empty lines not numbered, blank runs
		// squeezed (dropped newlines give no transfer), byte extremes, and a
		// file start that does not clear the blank run.
		configure(1'b1, 1'b1, 1'b1, 1'b1);
		send_text(CHAR_NEWLINE, 1'b1);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text(CHAR_NEWLINE, 1'b1);
		send_text(8'h00, 1'b0);
		send_text(8'hFF, 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text(8'hFF, 1'b1);
		send_text(8'h80, 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text(8'h7F, 1'b0);
		settle();

		// -- counting without numbering --------------------------------------
		// Full speed newlines with numbering off still advance the counter;
		// then print a few two-digit numbers and restart.
		configure(1'b0, 1'b0, 1'b0, 1'b0);
		send_text(CHAR_NEWLINE, 1'b1);
		for (int i = 0; i < COUNT_LINES; i++)
			send_text(CHAR_NEWLINE, 1'b0);
		settle();
		configure(1'b1, 1'b0, 1'b0, 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text("k", 1'b0);
		send_text(CHAR_NEWLINE, 1'b0);
		send_text("m", 1'b0);
		settle();
		configure(1'b1, 1'b0, 1'b0, 1'b1);
		send_text("q", 1'b1);
		settle();

		// -- random phases ---------------------------------------------------
		// All sixteen option settings; every fourth phase draws no random gaps or
		// stalls. Text is newline heavy so blank runs and line starts are
		// frequent, with occasional file starts anywhere in a line.
		for (int phase = 0; phase < 16; phase++) begin
			opts = phase[3:0];
			configure(opts[0], opts[1], opts[2], opts[3]);
			if (phase % 4 == 1) begin
				gap_max   = 0;
				stall_max = 0;
			end else begin
				gap_max   = $urandom_range(0, 11);
				stall_max = 11;
			end
			// long listing hold-off while text keeps coming: the queue fills
			// and text.ready must drop
			if (phase == 6) begin
				gap_max      = 0;
				listing_hold = 80;
			end
			for (int i = 0; i < 21; i++) begin
				// sender stops mid-phase until the listing has caught up
				if (phase == 9 && i == 11)
					wait_drained();
				fs = ($urandom_range(0, 15) == 0);
				if ($urandom_range(0, 99) < 35)
					b = CHAR_NEWLINE;
				else
					b = 8'($urandom_range(0, 255));
				send_text(b, fs);
			end
			settle();
		end

		// -- end of run ------------------------------------------------------
		repeat (20) @(negedge clk);
		if (board.pending() != 0)
			$display("%0t listing: %0d expected bytes never arrived", $time, board.pending());
		if (board.errors == 0 && board.pending() == 0)
			$display("text_line_number_squeeze_filter regression: pass");
		else
			$display("text_line_number_squeeze_filter regression: fail");
		$finish;
	end

	// Hard limit, several times the slowest correct run.
	initial begin
		#2_000_000;
		$display("%0t timeout with %0d listing bytes outstanding", $time, board.pending());
		$display("text_line_number_squeeze_filter regression: fail");
		$finish;
	end

endmodule
